### sv/order_book_price_level_table_unit_assert.svh
// Assertion macros shared by the order book table unit.
`ifndef ORDER_BOOK_PRICE_LEVEL_TABLE_UNIT_ASSERT_SVH
`define ORDER_BOOK_PRICE_LEVEL_TABLE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define OPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order book assertion failed");
`define OPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order book assertion failed");
`else
`define OPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/opb_pkg.sv
`timescale 1ns / 1ps
package opb_pkg;
    localparam int TS_W    = 32;
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 40;
    localparam int DEPTH_W = 5;
    localparam int CMD_W   = 2;
    localparam int CNT_W   = 6;

    localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SNAPSHOT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    typedef enum logic [1:0] {
        OP_UPDATE,
        OP_SNAPSHOT,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [TS_W-1:0]     timestamp;
        logic                side;
        logic [PRICE_W-1:0]  price;
        logic [VOL_W-1:0]    volume;
        logic [DEPTH_W-1:0]  depth;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] ask_count;
        logic [CNT_W-1:0] bid_count;
        logic             busy;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SNAP
    } back_state_t;
endpackage

### sv/order_book_price_level_table_unit.sv
// Two sorted price level tables (asks ascending, bids descending), each holding up
// to LEVELS levels with the best at the front. Items pass through a two-entry
// queue into the table unit. An update first removes any level at the same price
// and then, in the cycle after, shifts in the new level, or only removes when the
// volume is zero; a clear empties both tables. A snapshot starts when it is taken
// from the queue and then sends one transfer per cycle while the output does not
// stall, na + nb transfers (at least one) for the asks then the bids. Result
// transfers wait in an output register, so the queue keeps filling while the
// output side stalls.
`timescale 1ns / 1ps
`include "order_book_price_level_table_unit_assert.svh"
module order_book_price_level_table_unit
    import opb_pkg::*;
#(
    parameter int LEVELS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [TS_W-1:0]    timestamp,
    input  logic               side,
    input  logic [PRICE_W-1:0] price,
    input  logic [VOL_W-1:0]   volume,
    input  logic [DEPTH_W-1:0] snapshot_depth,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               out_side,
    output logic [PRICE_W-1:0] out_price,
    output logic [VOL_W-1:0]   out_volume,
    output logic [TS_W-1:0]    out_timestamp,
    output logic               book_empty,
    output logic               last_of_run
);
    logic         item_valid;
    item_t        item;
    logic         item_pop;
    back_status_t status;

    opb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .timestamp      (timestamp),
        .side           (side),
        .price          (price),
        .volume         (volume),
        .snapshot_depth (snapshot_depth),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop)
    );

    opb_back #(
        .LEVELS (LEVELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_side      (out_side),
        .out_price     (out_price),
        .out_volume    (out_volume),
        .out_timestamp (out_timestamp),
        .book_empty    (book_empty),
        .last_of_run   (last_of_run),
        .status        (status)
    );

    `OPB_ASSERT_IMP(a_empty_is_last, clk, rst_n, out_valid && book_empty, last_of_run && out_price == '0 && out_volume == '0)
    `OPB_ASSERT_IMP(a_ask_bound, clk, rst_n, 1'b1, status.ask_count <= CNT_W'(LEVELS))
    `OPB_ASSERT_IMP(a_bid_bound, clk, rst_n, 1'b1, status.bid_count <= CNT_W'(LEVELS))
    `OPB_ASSERT_NXT(a_pop_only_idle, clk, rst_n, item_pop && item.op == OP_SNAPSHOT, status.busy)
endmodule

### sv/opb_front.sv
`timescale 1ns / 1ps
module opb_front
    import opb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [TS_W-1:0]    timestamp,
    input  logic               side,
    input  logic [PRICE_W-1:0] price,
    input  logic [VOL_W-1:0]   volume,
    input  logic [DEPTH_W-1:0] snapshot_depth,
    output logic               item_valid,
    output item_t              item,
    input  logic               item_pop
);
    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        known;
    op_t         op;
    logic        push;
    item_t       new_item;

    // Command codes with no meaning are taken and then dropped.
    always_comb
    begin
        known = 1'b1;
        op    = OP_UPDATE;
        unique case (command)
            CMD_UPDATE:   op = OP_UPDATE;
            CMD_SNAPSHOT: op = OP_SNAPSHOT;
            CMD_CLEAR:    op = OP_CLEAR;
            default:      known = 1'b0;
        endcase
    end

    assign in_stall   = (fill_reg == 2'd2);
    assign push       = in_valid && !in_stall && known;
    assign item_valid = (fill_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.op        = op;
        new_item.timestamp = timestamp;
        new_item.side      = side;
        new_item.price     = price;
        new_item.volume    = volume;
        new_item.depth     = snapshot_depth;
        fill_next = fill_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (item_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= new_item;
    end
endmodule

### sv/opb_back.sv
`timescale 1ns / 1ps
module opb_back
    import opb_pkg::*;
#(
    parameter int LEVELS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  item_t              item,
    output logic               item_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               out_side,
    output logic [PRICE_W-1:0] out_price,
    output logic [VOL_W-1:0]   out_volume,
    output logic [TS_W-1:0]    out_timestamp,
    output logic               book_empty,
    output logic               last_of_run,
    output back_status_t       status
);
    localparam int IW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW   = $clog2(LEVELS + 1);
    localparam int KW   = CW + 1;
    localparam int CMPW = (CW > DEPTH_W) ? CW : DEPTH_W;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [PRICE_W-1:0] price_reg [2][LEVELS];
    logic [VOL_W-1:0]   vol_reg   [2][LEVELS];
    logic [CW-1:0]      count_reg [2];
    logic [TS_W-1:0]    time_reg;
    item_t              cur_reg;
    logic [CW-1:0]      na_reg;
    logic [KW-1:0]      total_reg;
    logic [KW-1:0]      k_reg;

    logic               out_valid_reg;
    logic               out_side_reg;
    logic [PRICE_W-1:0] out_price_reg;
    logic [VOL_W-1:0]   out_volume_reg;
    logic [TS_W-1:0]    out_ts_reg;
    logic               out_empty_reg;
    logic               out_last_reg;

    // Control decoded from the state.
    logic               pop;
    logic               do_remove;
    logic               do_insert;
    logic               do_clear;
    logic               do_snap_start;
    logic               emit;

    logic               sel_side;
    logic [PRICE_W-1:0] sel_price;
    logic [VOL_W-1:0]   sel_vol;
    logic [CW-1:0]      old_n;
    logic [PRICE_W-1:0] pr_sel [LEVELS];
    logic [VOL_W-1:0]   vo_sel [LEVELS];
    logic [PRICE_W-1:0] rm_price [LEVELS];
    logic [VOL_W-1:0]   rm_vol   [LEVELS];
    logic [PRICE_W-1:0] in_price [LEVELS];
    logic [VOL_W-1:0]   in_vol   [LEVELS];
    logic [LEVELS-1:0]  ge;
    logic               found;
    logic               any_ahead;
    logic               place;
    logic [CW-1:0]      n_removed;
    logic [CW-1:0]      n_inserted;

    logic [CW-1:0]      na;
    logic [CW-1:0]      nb;
    logic               snap_side;
    logic [KW-1:0]      snap_pos;
    logic [IW-1:0]      snap_idx;
    logic               snap_last;
    logic               snap_none;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.op)
                        OP_UPDATE:
                            state_next = (item.volume != '0) ? ST_INSERT : ST_IDLE;
                        OP_SNAPSHOT: state_next = ST_SNAP;
                        OP_CLEAR:    state_next = ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INSERT: state_next = ST_IDLE;
            ST_SNAP:
            begin
                if (emit && snap_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop           = (state_reg == ST_IDLE) && item_valid;
        do_remove     = pop && (item.op == OP_UPDATE);
        do_clear      = pop && (item.op == OP_CLEAR);
        do_snap_start = pop && (item.op == OP_SNAPSHOT);
        do_insert     = (state_reg == ST_INSERT);
        emit          = (state_reg == ST_SNAP) && (!out_valid_reg || !out_stall);
    end

    assign item_pop = pop;

    // One side of the book is worked on at a time: the removal uses the item at
    // the head of the queue, the insertion the item latched for the next cycle.
    always_comb
    begin
        sel_side  = (state_reg == ST_IDLE) ? item.side   : cur_reg.side;
        sel_price = (state_reg == ST_IDLE) ? item.price  : cur_reg.price;
        sel_vol   = cur_reg.volume;
        old_n     = count_reg[sel_side];
        for (int i = 0; i < LEVELS; i++)
        begin
            pr_sel[i] = price_reg[sel_side][i];
            vo_sel[i] = vol_reg[sel_side][i];
        end
    end

    // Removal: every entry from the matching one upward takes its upper
    // neighbor.
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            found = found || ((CW'(i) < old_n) && (pr_sel[i] == sel_price));
            if (found && (i < LEVELS - 1))
            begin
                rm_price[i] = pr_sel[(i + 1) % LEVELS];
                rm_vol[i]   = vo_sel[(i + 1) % LEVELS];
            end
            else
            begin
                rm_price[i] = pr_sel[i];
                rm_vol[i]   = vo_sel[i];
            end
        end
        n_removed = old_n - CW'(found);
    end

    // Insertion: ge marks the entries at or behind the insert position; the
    // table is sorted, so ge is a run of ones up to the top.
    always_comb
    begin
        any_ahead = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            logic ahead;
            ahead = (CW'(i) < old_n) &&
                    (sel_side ? (sel_price > pr_sel[i]) : (sel_price < pr_sel[i]));
            any_ahead = any_ahead || ahead;
            ge[i] = ahead || (CW'(i) >= old_n);
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            if (!ge[i])
            begin
                in_price[i] = pr_sel[i];
                in_vol[i]   = vo_sel[i];
            end
            else if (i == 0 || !ge[(i + LEVELS - 1) % LEVELS])
            begin
                in_price[i] = sel_price;
                in_vol[i]   = sel_vol;
            end
            else
            begin
                in_price[i] = pr_sel[(i + LEVELS - 1) % LEVELS];
                in_vol[i]   = vo_sel[(i + LEVELS - 1) % LEVELS];
            end
        end
        place      = !((old_n >= CW'(LEVELS)) && !any_ahead);
        n_inserted = (old_n >= CW'(LEVELS)) ? CW'(LEVELS) : old_n + CW'(1);
    end

    // Snapshot bounds and the level that goes out next.
    always_comb
    begin
        na = count_reg[0];
        nb = count_reg[1];
        if (item.depth != '0)
        begin
            if (CMPW'(count_reg[0]) > CMPW'(item.depth))
                na = CW'(item.depth);
            if (CMPW'(count_reg[1]) > CMPW'(item.depth))
                nb = CW'(item.depth);
        end
        snap_none = (total_reg == '0);
        snap_side = (k_reg >= KW'(na_reg));
        snap_pos  = snap_side ? (k_reg - KW'(na_reg)) : k_reg;
        snap_idx  = snap_pos[IW-1:0];
        snap_last = snap_none || ((k_reg + KW'(1)) == total_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_remove || do_clear)
                time_reg <= item.timestamp;
            if (do_clear)
            begin
                count_reg[0] <= '0;
                count_reg[1] <= '0;
            end
            else if (do_remove)
                count_reg[sel_side] <= n_removed;
            else if (do_insert && place)
                count_reg[sel_side] <= n_inserted;
            if (do_snap_start)
                k_reg <= '0;
            else if (emit)
                k_reg <= k_reg + KW'(1);
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= item;
        if (do_snap_start)
        begin
            na_reg    <= na;
            total_reg <= KW'(na) + KW'(nb);
        end
        if (do_remove)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                price_reg[sel_side][i] <= rm_price[i];
                vol_reg[sel_side][i]   <= rm_vol[i];
            end
        end
        else if (do_insert && place)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                price_reg[sel_side][i] <= in_price[i];
                vol_reg[sel_side][i]   <= in_vol[i];
            end
        end
        if (emit)
        begin
            out_side_reg   <= snap_none ? 1'b0 : snap_side;
            out_price_reg  <= snap_none ? '0 : price_reg[snap_side][snap_idx];
            out_volume_reg <= snap_none ? '0 : vol_reg[snap_side][snap_idx];
            out_ts_reg     <= time_reg;
            out_empty_reg  <= snap_none;
            out_last_reg   <= snap_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_side      = out_side_reg;
    assign out_price     = out_price_reg;
    assign out_volume    = out_volume_reg;
    assign out_timestamp = out_ts_reg;
    assign book_empty    = out_empty_reg;
    assign last_of_run   = out_last_reg;

    always_comb
    begin
        status.ask_count = CNT_W'(count_reg[0]);
        status.bid_count = CNT_W'(count_reg[1]);
        status.busy      = (state_reg != ST_IDLE);
    end
endmodule
